// File: hdl/alc_pkg.sv
// Shared types, keyword table and lookup function for the response line classifier.
package alc_pkg;

  localparam int NumKeys  = 17;
  localparam int KeySlots = 32;
  localparam int PosW     = 5;
  localparam int EntryW   = 5;
  localparam int CodeW    = 5;

  localparam logic [PosW-1:0] PosMax = 5'd31;

  localparam logic       KindPayload = 1'b0;
  localparam logic       KindEvent   = 1'b1;
  localparam logic [CodeW-1:0] EvUnknown = 5'd0;

  // Keyword text, right aligned, zero filled on the left.
  localparam logic [KeySlots*8-1:0] KeyText [NumKeys] = '{
    "OK",
    "ERROR",
    "+GETTIME:",
    "+FACEVENT:",
    "+MQTTRECV:0,",
    "+MQTTEVENT:CONNECT,SUCCESS",
    "+WEVENT:AP_UP",
    "+WEVENT:CONNECTING",
    "+WEVENT:CONNECTTED",
    "+WEVENT:TIMEOUT",
    "+WEVENT:UNBIND,SUCCESS",
    "+OTAEVENT:DOWNLOADING",
    "+OTAEVENT:INSTALLING",
    "+OTAEVENT:SUCCESS",
    "+MCUOTAEVENT:VERSION,",
    "+MCUOTAEVENT:DOWNLOAD,DONE",
    "+MCUOTAEVENT:TRANSPORT,REBOOT"
  };

  localparam logic [PosW-1:0] KeyLen [NumKeys] = '{
    5'd2, 5'd5, 5'd9, 5'd10, 5'd12, 5'd26, 5'd13, 5'd18, 5'd18,
    5'd15, 5'd22, 5'd21, 5'd20, 5'd17, 5'd21, 5'd26, 5'd29
  };

  localparam logic [CodeW-1:0] KeyCode [NumKeys] = '{
    5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9,
    5'd10, 5'd11, 5'd12, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16
  };

  localparam logic [NumKeys-1:0] KeyParam = 17'b0_0100_0000_0001_1100;

  typedef struct packed {
    logic             kind;
    logic [7:0]       payload;
    logic [CodeW-1:0] code;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t res;
  } push_t;

  // Character of keyword k at position pos; zero past the keyword end.
  function automatic logic [7:0] key_char(input int k, input logic [PosW-1:0] pos);
    int idx;
    idx = int'(KeyLen[k]) - 1 - int'(pos);
    if (idx < 0) begin
      return 8'h00;
    end
    return KeyText[k][8*idx +: 8];
  endfunction

endpackage

// File: hdl/alc_matcher.sv
// Per-character keyword compare, line state registers and result generation.
module alc_matcher import alc_pkg::*; #(
  parameter int PAYLOAD_MAX = 63
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] line_byte_i,
  input  logic       end_of_line_i,
  output push_t      push_o
);

  localparam int CntW = $clog2(PAYLOAD_MAX + 1);

  logic [NumKeys-1:0] live_q, live_d, live_upd;
  logic [PosW-1:0]    pos_q, pos_d, pos_next;
  logic [EntryW-1:0]  matched_q, matched_d, matched_idx, first_idx, done_idx;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               nonempty_q, nonempty_d;
  logic               closed_q, closed_d;
  logic               first_found, done_found;
  logic [CodeW-1:0]   eol_code;
  push_t              push;

  assign matched_idx = matched_q - EntryW'(1);
  assign pos_next    = (pos_q == PosMax) ? pos_q : pos_q + PosW'(1);

  always_comb begin
    live_upd = live_q;
    for (int k = 0; k < NumKeys; k++) begin
      if (live_q[k] && (pos_q < KeyLen[k]) && (key_char(k, pos_q) != line_byte_i)) begin
        live_upd[k] = 1'b0;
      end
    end
  end

  // Lowest live keyword after this character, and lowest complete one at line end.
  always_comb begin
    first_found = 1'b0;
    first_idx   = '0;
    done_found  = 1'b0;
    done_idx    = '0;
    for (int k = NumKeys - 1; k >= 0; k--) begin
      if (live_upd[k]) begin
        first_found = 1'b1;
        first_idx   = EntryW'(k);
      end
      if (live_q[k] && (KeyLen[k] <= pos_q)) begin
        done_found = 1'b1;
        done_idx   = EntryW'(k);
      end
    end
  end

  always_comb begin
    if (matched_q != '0) begin
      eol_code = KeyCode[matched_idx];
    end else if (done_found) begin
      eol_code = KeyCode[done_idx];
    end else begin
      eol_code = EvUnknown;
    end
  end

  always_comb begin
    live_d      = live_q;
    pos_d       = pos_q;
    matched_d   = matched_q;
    cnt_d       = cnt_q;
    nonempty_d  = nonempty_q;
    closed_d    = closed_q;
    push.push   = 1'b0;
    push.res    = '{kind: KindPayload, payload: line_byte_i, code: EvUnknown};
    if (accept_i) begin
      if (end_of_line_i) begin
        push.push    = nonempty_q;
        push.res     = '{kind: KindEvent, payload: 8'h00, code: eol_code};
        live_d       = '1;
        pos_d        = '0;
        matched_d    = '0;
        cnt_d        = '0;
        nonempty_d   = 1'b0;
        closed_d     = 1'b0;
      end else if (!closed_q) begin
        if (line_byte_i == 8'h00) begin
          closed_d = 1'b1;
        end else begin
          nonempty_d = 1'b1;
          if (matched_q != '0) begin
            // forward parameter bytes until the payload limit, drop the rest
            if (KeyParam[matched_idx] && (cnt_q < CntW'(PAYLOAD_MAX))) begin
              cnt_d        = cnt_q + CntW'(1);
              push.push    = 1'b1;
              push.res     = '{kind: KindPayload, payload: line_byte_i,
                               code: KeyCode[matched_idx]};
            end
          end else begin
            live_d = live_upd;
            pos_d  = pos_next;
            if (first_found && (KeyLen[first_idx] <= pos_next)) begin
              matched_d = first_idx + EntryW'(1);
            end
          end
        end
      end
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q     <= '1;
      pos_q      <= '0;
      matched_q  <= '0;
      cnt_q      <= '0;
      nonempty_q <= 1'b0;
      closed_q   <= 1'b0;
    end else begin
      live_q     <= live_d;
      pos_q      <= pos_d;
      matched_q  <= matched_d;
      cnt_q      <= cnt_d;
      nonempty_q <= nonempty_d;
      closed_q   <= closed_d;
    end
  end

  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_of_line_i |=> (pos_q == '0) && (matched_q == '0) && (live_q == '1))
    else $error("line state not cleared after end of line");

  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(PAYLOAD_MAX))
    else $error("payload count beyond limit");

  a_match_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (matched_q != '0) |-> (matched_q <= EntryW'(NumKeys)) && live_q[matched_idx])
    else $error("settled entry is not a live keyword");

endmodule

// File: hdl/alc_out_buf.sv
// Two-entry output queue that decouples result delivery from input acceptance.
module alc_out_buf import alc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  result_t   slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop     = (cnt_q != 2'd0) && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign res_o   = slot0_q;

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_q;
    if (pop) begin
      slot0_d = slot1_q;
    end
    if (push_i.push) begin
      if ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop)) begin
        slot0_d = push_i.res;
      end else begin
        slot1_d = push_i.res;
      end
    end
    cnt_d = cnt_q + 2'(push_i.push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push |-> (cnt_q != 2'd2))
    else $error("result pushed into full queue");

  a_head_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && (res_o == $past(res_o)))
    else $error("stalled head result changed");

endmodule

// File: hdl/at_response_line_classifier_unit.sv
// Top level of the modem response line classifier.
// Each result is registered in the output queue and is presented when it reaches the queue head.
// Throughput: one input transaction per cycle; the two-entry output queue keeps input
// accepted while one result waits, and input stalls only when both entries are held.
// Reset clears all line state (every keyword live, position, match, counts) and
// empties the output queue; no clearing pass is needed.
module at_response_line_classifier_unit import alc_pkg::*; #(
  parameter int PAYLOAD_MAX = 63
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       line_byte_i,
  input  logic             end_of_line_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             result_kind_o,
  output logic [7:0]       payload_byte_o,
  output logic [CodeW-1:0] event_code_o
);

  logic    full;
  logic    accept;
  push_t   push;
  result_t res;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;

  alc_matcher #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_matcher (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .line_byte_i   (line_byte_i),
    .end_of_line_i (end_of_line_i),
    .push_o        (push)
  );

  alc_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res)
  );

  assign result_kind_o  = res.kind;
  assign payload_byte_o = res.payload;
  assign event_code_o   = res.code;

endmodule
